[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, empty under synthesis
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)

`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[sv/tcw_pkg.sv]
// ----------------------------------------------------------------------------
// text console writer package
// screen geometry defaults, cell codes and request opcodes
// ----------------------------------------------------------------------------
package tcw_pkg;

    localparam int DEF_COLUMNS = 80;
    localparam int DEF_ROWS    = 25;

    localparam logic [7:0] BLANK_CHAR     = 8'h20;
    localparam logic [7:0] RESET_ATTR     = 8'h07;
    localparam logic [7:0] NEWLINE_CODE   = 8'd10;
    localparam logic [7:0] BACKSPACE_CODE = 8'd8;

    localparam logic [1:0] OP_PUT   = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

endpackage

[sv/text_console_writer_unit.sv]
// ----------------------------------------------------------------------------
// text console writer unit
// character-cell console with a screen memory, cursor, scroll and clear
// ----------------------------------------------------------------------------
// A request is taken when i_start is high and o_busy is low. i_opcode selects
// put character, clear screen or read one cell. Every request gives exactly one
// result, shown for one cycle with o_result_valid: the linear cursor position
// and, for a read, the character and attribute of the cell.
// The screen lives in one memory of COLUMNS*ROWS 16-bit cells with a registered
// read; scroll and clear walk it one cell per cycle.
// Sequence after acceptance:
//   put without scroll, out-of-range read, unused opcode: result in the next
//   cycle, and the next request may be taken in that same cycle
//   in-range read: memory read, then result
//   put that scrolls: rows copied up one row through the single read port,
//   then the last row blanked, then result
//   clear: one memory write per cell, then result
// After reset the unit blanks the whole memory with o_busy high; the attribute
// register may be written during that time.
// The receiver cannot stall: results must be taken in the cycle they appear.
// i_cfg_we with i_cfg_wdata sets the attribute used for characters and for the blanks of clear and scroll.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module text_console_writer_unit #(
    parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
    parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [1:0]  i_opcode,
    input  logic [7:0]  i_char_code,
    input  logic [10:0] i_cell_index,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata,
    output logic        o_result_valid,
    output logic [10:0] o_cursor_pos,
    output logic [7:0]  o_cell_char,
    output logic [7:0]  o_cell_attr
);

    localparam int CELLS     = COLUMNS * ROWS;
    localparam int LAST_BASE = (ROWS - 1) * COLUMNS;
    localparam int AW        = $clog2(CELLS);
    localparam int CW        = $clog2(COLUMNS);
    localparam int RW        = $clog2(ROWS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_SCROLL,
        ST_SCROLL_LAST,
        ST_FILL
    } t_state;

    t_state          r_state;
    logic [15:0]     r_mem [CELLS];
    logic [15:0]     r_rdata;
    logic [AW-1:0]   r_addr;
    logic [AW-1:0]   r_waddr;
    logic            r_wpend;
    logic            r_report;
    logic [7:0]      r_attr;
    logic [CW-1:0]   r_col;
    logic [RW-1:0]   r_row;
    logic [AW-1:0]   r_pos;

    logic [CW-1:0]   n_col;
    logic [RW-1:0]   n_row;
    logic [AW-1:0]   n_pos;
    logic            n_scroll;
    logic            put_we;

    logic            accept;
    logic            rd_in_range;
    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    logic [15:0]     mem_wdata;
    logic [AW-1:0]   mem_raddr;

    assign o_busy      = (r_state != ST_IDLE);
    assign accept      = i_start && !o_busy;
    assign rd_in_range = ({21'd0, i_cell_index} < 32'(CELLS));

    // cursor movement for a put request
    always_comb begin
        n_col    = r_col;
        n_row    = r_row;
        n_pos    = r_pos;
        n_scroll = 1'b0;
        put_we   = 1'b0;
        if (i_char_code == tcw_pkg::NEWLINE_CODE) begin
            n_col = '0;
            n_pos = r_pos - AW'(r_col) + AW'(COLUMNS);
            if (r_row == RW'(ROWS - 1)) begin
                n_scroll = 1'b1;
            end else begin
                n_row = r_row + 1'b1;
            end
        end else if (i_char_code == tcw_pkg::BACKSPACE_CODE) begin
            if (r_col != '0) begin
                n_col = r_col - 1'b1;
                n_pos = r_pos - 1'b1;
            end else if (r_row != '0) begin
                n_row = r_row - 1'b1;
                n_col = CW'(COLUMNS - 1);
                n_pos = r_pos - 1'b1;
            end
        end else begin
            put_we = 1'b1;
            n_pos  = r_pos + 1'b1;
            if (r_col == CW'(COLUMNS - 1)) begin
                n_col = '0;
                if (r_row == RW'(ROWS - 1)) begin
                    n_scroll = 1'b1;
                end else begin
                    n_row = r_row + 1'b1;
                end
            end else begin
                n_col = r_col + 1'b1;
            end
        end
        if (n_scroll) begin
            n_row = RW'(ROWS - 1);
            n_col = '0;
            n_pos = AW'(LAST_BASE);
        end
    end

    // memory port control
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_addr;
        mem_wdata = {(r_report ? r_attr : tcw_pkg::RESET_ATTR), tcw_pkg::BLANK_CHAR};
        mem_raddr = AW'(i_cell_index);
        unique case (r_state)
            ST_IDLE: begin
                if (accept && (i_opcode == tcw_pkg::OP_PUT) && put_we) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_pos;
                    mem_wdata = {r_attr, i_char_code};
                end
            end
            ST_READ: begin
            end
            ST_SCROLL: begin
                mem_raddr = r_addr + AW'(COLUMNS);
                mem_we    = r_wpend;
                mem_waddr = r_waddr;
                mem_wdata = r_rdata;
            end
            ST_SCROLL_LAST: begin
                mem_we    = 1'b1;
                mem_waddr = r_waddr;
                mem_wdata = r_rdata;
            end
            ST_FILL: begin
                mem_we = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // screen memory
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_FILL;
            r_addr         <= '0;
            r_waddr        <= '0;
            r_wpend        <= 1'b0;
            r_report       <= 1'b0;
            r_attr         <= tcw_pkg::RESET_ATTR;
            r_col          <= '0;
            r_row          <= '0;
            r_pos          <= '0;
            o_result_valid <= 1'b0;
            o_cursor_pos   <= '0;
            o_cell_char    <= '0;
            o_cell_attr    <= '0;
        end else begin
            o_result_valid <= 1'b0;
            if (i_cfg_we) begin
                r_attr <= i_cfg_wdata;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        o_cell_char <= '0;
                        o_cell_attr <= '0;
                        unique case (i_opcode)
                            tcw_pkg::OP_PUT: begin
                                r_col <= n_col;
                                r_row <= n_row;
                                r_pos <= n_pos;
                                if (n_scroll) begin
                                    r_state  <= ST_SCROLL;
                                    r_addr   <= '0;
                                    r_wpend  <= 1'b0;
                                    r_report <= 1'b1;
                                end else begin
                                    o_result_valid <= 1'b1;
                                    o_cursor_pos   <= 11'(n_pos);
                                end
                            end
                            tcw_pkg::OP_CLEAR: begin
                                r_col    <= '0;
                                r_row    <= '0;
                                r_pos    <= '0;
                                r_addr   <= '0;
                                r_report <= 1'b1;
                                r_state  <= ST_FILL;
                            end
                            tcw_pkg::OP_READ: begin
                                if (rd_in_range) begin
                                    r_state <= ST_READ;
                                end else begin
                                    o_result_valid <= 1'b1;
                                    o_cursor_pos   <= 11'(r_pos);
                                end
                            end
                            default: begin
                                o_result_valid <= 1'b1;
                                o_cursor_pos   <= 11'(r_pos);
                            end
                        endcase
                    end
                end
                ST_READ: begin
                    o_result_valid <= 1'b1;
                    o_cursor_pos   <= 11'(r_pos);
                    o_cell_char    <= r_rdata[7:0];
                    o_cell_attr    <= r_rdata[15:8];
                    r_state        <= ST_IDLE;
                end
                ST_SCROLL: begin
                    r_waddr <= r_addr;
                    r_wpend <= 1'b1;
                    if (r_addr == AW'(LAST_BASE - 1)) begin
                        r_state <= ST_SCROLL_LAST;
                    end else begin
                        r_addr <= r_addr + 1'b1;
                    end
                end
                ST_SCROLL_LAST: begin
                    r_addr  <= AW'(LAST_BASE);
                    r_wpend <= 1'b0;
                    r_state <= ST_FILL;
                end
                ST_FILL: begin
                    if (r_addr == AW'(CELLS - 1)) begin
                        r_state <= ST_IDLE;
                        if (r_report) begin
                            o_result_valid <= 1'b1;
                            o_cursor_pos   <= 11'(r_pos);
                            o_cell_char    <= '0;
                            o_cell_attr    <= '0;
                        end
                    end else begin
                        r_addr <= r_addr + 1'b1;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    `ASSERT_IMPLIES(a_result_when_idle, i_clk, i_rst_n, o_result_valid, !o_busy)
    `ASSERT_IMPLIES(a_cursor_bounds, i_clk, i_rst_n, 1'b1,
        (r_col <= CW'(COLUMNS - 1)) && (r_row <= RW'(ROWS - 1)))
    `ASSERT_IMPLIES(a_pos_matches, i_clk, i_rst_n, 1'b1,
        (32'(r_pos) == (32'(r_row) * COLUMNS + 32'(r_col))))
    `ASSERT_IMPLIES(a_scroll_range, i_clk, i_rst_n, r_state == ST_SCROLL,
        (32'(r_addr) < LAST_BASE) && (r_row == RW'(ROWS - 1)))
    `ASSERT_NEXT(a_read_issue, i_clk, i_rst_n,
        accept && (i_opcode == tcw_pkg::OP_READ) && rd_in_range, r_state == ST_READ)

endmodule
